// ===== sv/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_SEMI = 8'd59;

    typedef enum logic [1:0] {
        OUT_RUNNING    = 2'd0,
        OUT_COMPLETE   = 2'd1,
        OUT_INCOMPLETE = 2'd2,
        OUT_MALFORMED  = 2'd3
    } outcome_t;

    typedef enum logic [9:0] {
        PH_SIZE      = 10'b00_0000_0001,
        PH_EXT       = 10'b00_0000_0010,
        PH_SIZE_CR   = 10'b00_0000_0100,
        PH_DATA      = 10'b00_0000_1000,
        PH_DATA_END  = 10'b00_0001_0000,
        PH_DATA_CR   = 10'b00_0010_0000,
        PH_TRL_START = 10'b00_0100_0000,
        PH_TRL_LINE  = 10'b00_1000_0000,
        PH_TRL_CR    = 10'b01_0000_0000,
        PH_FINAL_CR  = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.val = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.val = 4'(c - 8'h57);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== sv/http_chunked_body_decoder.sv =====
// channel   dir  tdata                    tuser                            tlast
// s_axis    in   [7:0] data_byte          -                                is_last
// m_axis    out  [7:0] payload_byte       [0] payload_valid, [2:1] outcome -
//
// one result per request; a request waits in the input register and
// its result is written to the output register on the next advance
// sustained rate is one request per cycle while m_axis is not stalled, limited by the single state update
// rst_n clears the parser state and both pipeline valid bits asynchronously
// a stalled m_axis holds its result; s_axis keeps taking a request while the
// input register is empty or moving forward
module http_chunked_body_decoder
    import hcbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0] m_axis_tuser    // [0] payload_valid, [2:1] outcome
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_flag_reg, out_flag_next;
    outcome_t   out_outcome_reg, out_outcome_next;

    phase_t                  phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    digit_seen_reg, digit_seen_next;
    outcome_t                latched_reg, latched_next;

    phase_t                  ph_step;
    logic [COUNT_BITS-1:0]   cnt_step;
    logic [COUNT_BITS-1:0]   cnt_dec;
    logic                    dig_step;
    outcome_t                lat_step;
    outcome_t                res_outcome;
    logic                    pay_step;
    hex_t                    hx;
    logic                    is_eol;
    logic                    in_acc;
    logic                    advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign hx      = hex_value(in_byte_reg);
    assign is_eol  = (in_byte_reg == CH_CR) || (in_byte_reg == CH_LF);
    assign cnt_dec = count_reg - COUNT_BITS'(1);

    always_comb
    begin
        ph_step  = phase_reg;
        cnt_step = count_reg;
        dig_step = digit_seen_reg;
        lat_step = latched_reg;
        pay_step = 1'b0;
        if (latched_reg == OUT_RUNNING)
        begin
            case (phase_reg)
                PH_SIZE, PH_EXT:
                begin
                    if (phase_reg == PH_SIZE && hx.ok)
                    begin
                        // a nonzero top nibble would be shifted out
                        if (count_reg[COUNT_BITS-1 -: 4] != 4'd0)
                        begin
                            lat_step = OUT_MALFORMED;
                        end
                        else
                        begin
                            cnt_step = {count_reg[COUNT_BITS-5:0], hx.val};
                            dig_step = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_SIZE && in_byte_reg == CH_SEMI)
                    begin
                        ph_step = PH_EXT;
                    end
                    else if (is_eol)
                    begin
                        if (!digit_seen_reg)
                        begin
                            lat_step = OUT_MALFORMED;
                        end
                        else if (in_byte_reg == CH_CR)
                        begin
                            ph_step = PH_SIZE_CR;
                        end
                        else
                        begin
                            ph_step = (count_reg == '0) ? PH_TRL_START : PH_DATA;
                        end
                    end
                    else if (phase_reg == PH_SIZE)
                    begin
                        lat_step = OUT_MALFORMED;
                    end
                end
                PH_SIZE_CR:
                begin
                    if (in_byte_reg == CH_LF)
                    begin
                        ph_step = (count_reg == '0) ? PH_TRL_START : PH_DATA;
                    end
                    else
                    begin
                        lat_step = OUT_MALFORMED;
                    end
                end
                PH_DATA:
                begin
                    cnt_step = cnt_dec;
                    pay_step = 1'b1;
                    if (cnt_dec == '0)
                    begin
                        ph_step = PH_DATA_END;
                    end
                end
                PH_DATA_END:
                begin
                    if (in_byte_reg == CH_CR)
                    begin
                        ph_step = PH_DATA_CR;
                    end
                    else if (in_byte_reg == CH_LF)
                    begin
                        ph_step  = PH_SIZE;
                        cnt_step = '0;
                        dig_step = 1'b0;
                    end
                    else
                    begin
                        lat_step = OUT_MALFORMED;
                    end
                end
                PH_DATA_CR:
                begin
                    if (in_byte_reg == CH_LF)
                    begin
                        ph_step  = PH_SIZE;
                        cnt_step = '0;
                        dig_step = 1'b0;
                    end
                    else
                    begin
                        lat_step = OUT_MALFORMED;
                    end
                end
                PH_TRL_START:
                begin
                    if (in_byte_reg == CH_CR)
                    begin
                        ph_step = PH_FINAL_CR;
                    end
                    else if (in_byte_reg == CH_LF)
                    begin
                        lat_step = OUT_COMPLETE;
                    end
                    else
                    begin
                        ph_step = PH_TRL_LINE;
                    end
                end
                PH_TRL_LINE:
                begin
                    if (in_byte_reg == CH_CR)
                    begin
                        ph_step = PH_TRL_CR;
                    end
                    else if (in_byte_reg == CH_LF)
                    begin
                        ph_step = PH_TRL_START;
                    end
                end
                PH_TRL_CR:
                begin
                    if (in_byte_reg == CH_LF)
                    begin
                        ph_step = PH_TRL_START;
                    end
                    else
                    begin
                        lat_step = OUT_MALFORMED;
                    end
                end
                PH_FINAL_CR:
                begin
                    lat_step = (in_byte_reg == CH_LF) ? OUT_COMPLETE : OUT_MALFORMED;
                end
                default:
                begin
                    lat_step = OUT_MALFORMED;
                end
            endcase
        end
    end

    always_comb
    begin
        res_outcome = lat_step;
        if (in_last_reg && lat_step == OUT_RUNNING)
        begin
            res_outcome = OUT_INCOMPLETE;
        end
    end

    always_comb
    begin
        in_valid_next    = in_valid_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_flag_next    = out_flag_reg;
        out_outcome_next = out_outcome_reg;
        phase_next       = phase_reg;
        count_next       = count_reg;
        digit_seen_next  = digit_seen_reg;
        latched_next     = latched_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            in_valid_next    = 1'b0;
            out_valid_next   = 1'b1;
            out_byte_next    = pay_step ? in_byte_reg : 8'd0;
            out_flag_next    = pay_step;
            out_outcome_next = res_outcome;
            if (in_last_reg)
            begin
                // end of buffer puts the parser back to its reset state
                phase_next      = PH_SIZE;
                count_next      = '0;
                digit_seen_next = 1'b0;
                latched_next    = OUT_RUNNING;
            end
            else
            begin
                phase_next      = ph_step;
                count_next      = cnt_step;
                digit_seen_next = dig_step;
                latched_next    = lat_step;
            end
        end
        if (in_acc)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_SIZE;
            count_reg       <= '0;
            digit_seen_reg  <= 1'b0;
            latched_reg     <= OUT_RUNNING;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            digit_seen_reg  <= digit_seen_next;
            latched_reg     <= latched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        out_byte_reg    <= out_byte_next;
        out_flag_reg    <= out_flag_next;
        out_outcome_reg <= out_outcome_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_outcome_reg, out_flag_reg};

endmodule

// ===== sv/hcbd_checker.sv =====
module hcbd_checker
    import hcbd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser
);

    // payload only flows while the parser is still running or the buffer ends incomplete
    a_payload_running: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tuser[2:1] == OUT_RUNNING || m_axis_tuser[2:1] == OUT_INCOMPLETE)
        else $error("payload byte reported with a finished outcome");

    // non-payload results carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("non-payload result carries a nonzero byte");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // with the output register empty the input side always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while the output register is empty");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import hcbd_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PARSE_TARGET = 1700;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        outcome_t   outcome;
    } body_out_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       pin;
        logic [7:0] data;
        logic       valid;
        outcome_t   outcome;
    } row_t;

    // pin = 1 rows carry the result typed in; the others go through the predictor
    localparam row_t DIRECTED [28] = '{
        // two-byte chunk with both data extremes, bare line ends, junk after the end
        '{"2",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{8'h00,  1'b0, 1'b1, 8'h00, 1'b1, OUT_RUNNING},
        '{8'hFF,  1'b0, 1'b1, 8'hFF, 1'b1, OUT_RUNNING},
        '{CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"0",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{CH_LF,  1'b0, 1'b1, 8'h00, 1'b0, OUT_COMPLETE},
        '{"x",    1'b1, 1'b1, 8'h00, 1'b0, OUT_COMPLETE},
        // cr on the size line followed by something else
        '{"F",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{CH_CR,  1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"x",    1'b1, 1'b1, 8'h00, 1'b0, OUT_MALFORMED},
        // line end with no digit
        '{CH_LF,  1'b1, 1'b1, 8'h00, 1'b0, OUT_MALFORMED},
        // bad character on the size line
        '{"g",    1'b1, 1'b1, 8'h00, 1'b0, OUT_MALFORMED},
        // ninth digit overflows the size counter
        '{"f",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"f",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"f",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"f",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"F",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"F",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"F",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"F",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"0",    1'b1, 1'b1, 8'h00, 1'b0, OUT_MALFORMED},
        // buffer ends while still parsing
        '{"a",    1'b1, 1'b1, 8'h00, 1'b0, OUT_INCOMPLETE},
        // data not followed by a line end
        '{"1",    1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, OUT_RUNNING},
        '{"Z",    1'b0, 1'b1, "Z",   1'b1, OUT_RUNNING},
        '{"Q",    1'b1, 1'b1, 8'h00, 1'b0, OUT_MALFORMED}
    };

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    // predictor state
    phase_t                body_phase;
    logic [COUNT_BITS-1:0] chunk_left;
    logic                  size_digit;
    outcome_t              body_verdict;

    body_out_t  decoded_q[$];
    logic [7:0] raw_body[$];

    int mismatches      = 0;
    int results_checked = 0;
    int live_bytes      = 0;
    int payload_bytes   = 0;
    int n_complete      = 0;
    int n_incomplete    = 0;
    int n_malformed     = 0;
    int idle_cycles     = 0;
    int rx_hold         = 0;
    bit calm            = 1'b0;

    http_chunked_body_decoder u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic void restart_size_line();
        body_phase = PH_SIZE;
        chunk_left = '0;
        size_digit = 1'b0;
    endfunction

    function automatic body_out_t decode_byte(input logic [7:0] c, input logic last);
        body_out_t  r;
        logic [7:0] folded;
        logic [3:0] nib;
        logic       is_hex;
        r.data  = 8'h00;
        r.valid = 1'b0;
        folded  = c | 8'h20;
        is_hex  = 1'b1;
        nib     = 4'd0;
        if (c >= "0" && c <= "9")
            nib = c[3:0];
        else if (folded >= "a" && folded <= "f")
            nib = folded[3:0] + 4'd9;
        else
            is_hex = 1'b0;

        if (body_verdict == OUT_RUNNING)
        begin
            case (body_phase)
                PH_SIZE, PH_EXT:
                begin
                    if (body_phase == PH_SIZE && is_hex)
                    begin
                        // any bit in the top nibble means the next shift overflows
                        if (chunk_left[COUNT_BITS-1 -: 4] != 4'd0)
                            body_verdict = OUT_MALFORMED;
                        else
                        begin
                            chunk_left = {chunk_left[COUNT_BITS-5:0], nib};
                            size_digit = 1'b1;
                        end
                    end
                    else if (body_phase == PH_SIZE && c == CH_SEMI)
                        body_phase = PH_EXT;
                    else if (c == CH_CR || c == CH_LF)
                    begin
                        if (!size_digit)
                            body_verdict = OUT_MALFORMED;
                        else if (c == CH_CR)
                            body_phase = PH_SIZE_CR;
                        else
                            body_phase = (chunk_left == '0) ? PH_TRL_START : PH_DATA;
                    end
                    else if (body_phase == PH_SIZE)
                        body_verdict = OUT_MALFORMED;
                end
                PH_SIZE_CR:
                begin
                    if (c == CH_LF)
                        body_phase = (chunk_left == '0) ? PH_TRL_START : PH_DATA;
                    else
                        body_verdict = OUT_MALFORMED;
                end
                PH_DATA:
                begin
                    chunk_left = chunk_left - 1'b1;
                    if (chunk_left == '0)
                        body_phase = PH_DATA_END;
                    r.data  = c;
                    r.valid = 1'b1;
                end
                PH_DATA_END:
                begin
                    if (c == CH_CR)
                        body_phase = PH_DATA_CR;
                    else if (c == CH_LF)
                        restart_size_line();
                    else
                        body_verdict = OUT_MALFORMED;
                end
                PH_DATA_CR:
                begin
                    if (c == CH_LF)
                        restart_size_line();
                    else
                        body_verdict = OUT_MALFORMED;
                end
                PH_TRL_START:
                begin
                    if (c == CH_CR)
                        body_phase = PH_FINAL_CR;
                    else if (c == CH_LF)
                        body_verdict = OUT_COMPLETE;
                    else
                        body_phase = PH_TRL_LINE;
                end
                PH_TRL_LINE:
                begin
                    if (c == CH_CR)
                        body_phase = PH_TRL_CR;
                    else if (c == CH_LF)
                        body_phase = PH_TRL_START;
                end
                PH_TRL_CR:
                begin
                    if (c == CH_LF)
                        body_phase = PH_TRL_START;
                    else
                        body_verdict = OUT_MALFORMED;
                end
                PH_FINAL_CR:
                begin
                    body_verdict = (c == CH_LF) ? OUT_COMPLETE : OUT_MALFORMED;
                end
                default:
                    body_verdict = OUT_MALFORMED;
            endcase
        end

        r.outcome = (last && body_verdict == OUT_RUNNING) ? OUT_INCOMPLETE : body_verdict;
        if (last)
        begin
            restart_size_line();
            body_verdict = OUT_RUNNING;
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + {4'd0, nib};
        return ($urandom_range(0, 1) ? "a" : "A") + {4'd0, nib} - 8'd10;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void put_eol();
        if ($urandom_range(0, 1))
            raw_body.push_back(CH_CR);
        raw_body.push_back(CH_LF);
    endfunction

    function automatic void put_size(input logic [31:0] n);
        int i;
        bit started;
        started = 1'b0;
        if ($urandom_range(0, 4) == 0)
            raw_body.push_back("0");
        for (i = 7; i >= 0; i--)
        begin
            if (n[i*4 +: 4] != 4'd0 || started || i == 0)
            begin
                raw_body.push_back(hex_char(n[i*4 +: 4]));
                started = 1'b1;
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            raw_body.push_back(CH_SEMI);
            repeat ($urandom_range(0, 5))
                raw_body.push_back(text_byte());
        end
        put_eol();
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("[%0t] result %0d: %s", $realtime, results_checked, what);
    endtask

    task automatic idle_tx(input int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic offer_byte(input logic [7:0] c, input logic last, output body_out_t want);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (body_verdict == OUT_RUNNING)
            live_bytes++;
        want = decode_byte(c, last);
        if (last)
        begin
            case (want.outcome)
                OUT_COMPLETE:   n_complete++;
                OUT_INCOMPLETE: n_incomplete++;
                default:        n_malformed++;
            endcase
        end
    endtask

    task automatic drain_results();
        idle_tx(1);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver side: random stalls plus one long hold-off
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                rx_hold--;
            end
            else if (burst > 0)
            begin
                m_axis_tready <= 1'b0;
                burst--;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(1, 8) - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        body_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            if (decoded_q.size() == 0)
                note_mismatch($sformatf("unexpected result data=%02h user=%03b",
                                        m_axis_tdata, m_axis_tuser));
            else
            begin
                want = decoded_q.pop_front();
                if (m_axis_tdata !== want.data)
                    note_mismatch($sformatf("payload_byte %02h, want %02h",
                                            m_axis_tdata, want.data));
                if (m_axis_tuser[0] !== want.valid)
                    note_mismatch($sformatf("payload_valid %b, want %b",
                                            m_axis_tuser[0], want.valid));
                if (m_axis_tuser[2:1] !== want.outcome)
                    note_mismatch($sformatf("outcome %0d, want %s",
                                            m_axis_tuser[2:1], want.outcome.name()));
                if (want.valid)
                    payload_bytes++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, decoded_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int        k;
        int        kind;
        int        n_buffers;
        logic [7:0] len;
        body_out_t want;
        n_buffers = 0;
        restart_size_line();
        body_verdict = OUT_RUNNING;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 28; k++)
        begin
            offer_byte(DIRECTED[k].b, DIRECTED[k].last, want);
            if (DIRECTED[k].pin)
            begin
                want.data    = DIRECTED[k].data;
                want.valid   = DIRECTED[k].valid;
                want.outcome = DIRECTED[k].outcome;
            end
            decoded_q.push_back(want);
        end
        drain_results();

        while (live_bytes < PARSE_TARGET)
        begin
            n_buffers++;
            // stop the receiver while bytes keep coming so the decoder backs up
            if (n_buffers == 12)
                rx_hold = HOLD_CYCLES;
            if (n_buffers == 40)
                drain_results();
            if (live_bytes > PARSE_TARGET - 250)
                calm = 1'b1;

            // well-formed body with random content
            raw_body.delete();
            repeat ($urandom_range(0, 3))
            begin
                len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(20, 60))
                                                  : 8'($urandom_range(1, 6));
                put_size({24'd0, len});
                repeat (len)
                    raw_body.push_back(8'($urandom_range(0, 255)));
                put_eol();
            end
            put_size(32'd0);
            repeat ($urandom_range(0, 2))
            begin
                repeat ($urandom_range(1, 6))
                    raw_body.push_back(text_byte());
                put_eol();
            end
            put_eol();
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    raw_body.push_back(8'($urandom_range(0, 255)));

            // some bodies get damaged, cut short or replaced
            kind = $urandom_range(0, 13);
            case (kind)
                0: raw_body[$urandom_range(0, raw_body.size() - 1)] = 8'($urandom_range(0, 255));
                1: raw_body = raw_body[0:$urandom_range(0, raw_body.size() - 1)];
                2: raw_body[$urandom_range(0, raw_body.size() - 1)] = CH_CR;
                3:
                begin
                    raw_body.delete();
                    repeat ($urandom_range(1, 12))
                    begin
                        case ($urandom_range(0, 5))
                            0: raw_body.push_back(hex_char(4'($urandom_range(0, 15))));
                            1: raw_body.push_back(CH_CR);
                            2: raw_body.push_back(CH_LF);
                            3: raw_body.push_back(CH_SEMI);
                            default: raw_body.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
                4:
                begin
                    // eight digits sit at the counter limit, nine mostly overflow
                    raw_body.delete();
                    repeat ($urandom_range(8, 9))
                        raw_body.push_back(hex_char(4'($urandom_range(0, 15))));
                    put_eol();
                    repeat ($urandom_range(0, 5))
                        raw_body.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase

            for (k = 0; k < raw_body.size(); k++)
            begin
                if (!calm && $urandom_range(0, 11) == 0)
                    idle_tx($urandom_range(1, 8));
                offer_byte(raw_body[k], k == raw_body.size() - 1, want);
                decoded_q.push_back(want);
            end
        end

        drain_results();
        repeat (8)
            @(posedge clk);
        $display("ran %0d random buffers after the directed set: %0d parsed bytes, %0d payload",
                 n_buffers, live_bytes, payload_bytes);
        $display("buffer ends: %0d complete, %0d incomplete, %0d malformed",
                 n_complete, n_incomplete, n_malformed);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hcbd_pkg.sv
sv/http_chunked_body_decoder.sv
sv/hcbd_checker.sv
tb/tb_top.sv
